FILE: design/kts_pkg.sv
// Shared types and constants for the Kahn topological sorter.
`default_nettype none

package kts_pkg;

    // Default size of the dependency graph
    localparam int MAX_NODES_DEF = 32;

    // Fixed field widths
    localparam int NODE_W = 5;
    localparam int POS_W  = 5;
    localparam int CFG_W  = 6;

    // Command codes; the fourth code is unused and does nothing
    typedef enum logic [1:0] {
        OP_ADD_EDGE,
        OP_CLEAR,
        OP_SORT
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_POP,
        ST_SCAN
    } state_t;

    // One command transaction
    typedef struct packed {
        op_t               op;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
    } cmd_t;

    // One result transaction
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  position;
        logic              last;
        logic              cyclic;
        logic              empty_res;
    } result_t;

    // Edge matrix write control
    typedef struct packed {
        logic add;
        logic clear;
    } mx_ctrl_t;

    // Ready queue control
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } q_ctrl_t;

endpackage

`default_nettype wire

FILE: design/kts_matrix.sv
// Adjacency bit matrix: one row per source node, single-bit read port.
`default_nettype none

module kts_matrix #(
    parameter int MAX_NODES = kts_pkg::MAX_NODES_DEF,
    parameter int IDX_W     = 5
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  kts_pkg::mx_ctrl_t    ctrl,
    input  wire [IDX_W-1:0]      wr_row,
    input  wire [IDX_W-1:0]      wr_col,
    input  wire [IDX_W-1:0]      rd_row,
    input  wire [IDX_W-1:0]      rd_col,
    output logic                 rd_bit
);

    logic [MAX_NODES-1:0] row_reg [MAX_NODES];

    // Set one edge bit, or drop every edge at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_NODES; r++)
            begin
                row_reg[r] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int r = 0; r < MAX_NODES; r++)
            begin
                row_reg[r] <= '0;
            end
        end
        else if (ctrl.add)
        begin
            row_reg[wr_row][wr_col] <= 1'b1;
        end
    end

    // Pick one bit for the sequencer
    assign rd_bit = row_reg[rd_row][rd_col];

endmodule

`default_nettype wire

FILE: design/kts_queue.sv
// FIFO of nodes whose in-degree has reached zero.
`default_nettype none

module kts_queue #(
    parameter int MAX_NODES = kts_pkg::MAX_NODES_DEF,
    parameter int IDX_W     = 5,
    parameter int CNT_W     = 6
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  kts_pkg::q_ctrl_t     ctrl,
    input  wire [IDX_W-1:0]      push_node,
    output logic [IDX_W-1:0]     head_node,
    output logic                 empty
);

    logic [IDX_W-1:0] slot_mem [MAX_NODES];
    logic [CNT_W-1:0] head_reg;
    logic [CNT_W-1:0] tail_reg;
    logic [CNT_W-1:0] head_next;
    logic [CNT_W-1:0] tail_next;

    // Advance the pointers; a new sort rewinds both
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctrl.clear)
        begin
            head_next = '0;
            tail_next = '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                tail_next = tail_reg + CNT_W'(1);
            end
            if (ctrl.pop)
            begin
                head_next = head_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Store a node at the tail
    always_ff @(posedge clk)
    begin
        if (ctrl.push && !ctrl.clear)
        begin
            slot_mem[tail_reg[IDX_W-1:0]] <= push_node;
        end
    end

    assign head_node = slot_mem[head_reg[IDX_W-1:0]];
    assign empty     = (head_reg == tail_reg);

endmodule

`default_nettype wire

FILE: design/kts_seq.sv
// Sort sequencer: in-degree counts, shared count unit and result register.
`default_nettype none

module kts_seq #(
    parameter int MAX_NODES = kts_pkg::MAX_NODES_DEF,
    parameter int IDX_W     = 5,
    parameter int CNT_W     = 6
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start_sort,
    output logic                       busy,
    input  wire                        cfg_we,
    input  wire [kts_pkg::CFG_W-1:0]   cfg_wdata,
    output logic [IDX_W-1:0]           mx_row,
    output logic [IDX_W-1:0]           mx_col,
    input  wire                        mx_bit,
    output kts_pkg::q_ctrl_t           q_ctrl,
    output logic [IDX_W-1:0]           q_push_node,
    input  wire [IDX_W-1:0]            q_head_node,
    input  wire                        q_empty,
    output logic                       result_strobe,
    output kts_pkg::result_t           result
);

    kts_pkg::state_t              state_reg;
    kts_pkg::state_t              state_next;
    logic [kts_pkg::CFG_W-1:0]    node_count_reg;
    logic [CNT_W-1:0]             n_reg;
    logic [CNT_W-1:0]             n_clip;
    logic [CNT_W-1:0]             n_last;
    logic [IDX_W-1:0]             i_reg;
    logic [IDX_W-1:0]             j_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [CNT_W-1:0]             acc_reg;
    logic [CNT_W-1:0]             placed_reg;
    logic [CNT_W-1:0]             placed_inc;
    logic                         i_last;
    logic                         j_last;

    logic [CNT_W-1:0]             indeg_mem [MAX_NODES];
    logic [CNT_W-1:0]             indeg_rd;
    logic                         indeg_we;
    logic [IDX_W-1:0]             indeg_waddr;

    logic [CNT_W-1:0]             unit_a;
    logic [CNT_W-1:0]             unit_b;
    logic [CNT_W-1:0]             unit_y;

    logic                         emit;
    kts_pkg::result_t             emit_res;
    logic                         result_strobe_reg;
    kts_pkg::result_t             result_reg;

    // Clip the configured count to the array size
    assign n_clip = (int'(node_count_reg) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                       : CNT_W'(node_count_reg);
    assign n_last     = n_reg - CNT_W'(1);
    assign i_last     = (CNT_W'(i_reg) == n_last);
    assign j_last     = (CNT_W'(j_reg) == n_last);
    assign placed_inc = placed_reg + CNT_W'(1);
    assign indeg_rd   = indeg_mem[j_reg];

    // Matrix read address: column walk while counting, row walk while scanning
    assign mx_row = (state_reg == kts_pkg::ST_COUNT) ? j_reg : idx_reg;
    assign mx_col = (state_reg == kts_pkg::ST_COUNT) ? i_reg : j_reg;

    // Shared count unit: accumulate one edge bit, or decrement an in-degree
    assign unit_a = (state_reg == kts_pkg::ST_COUNT) ? acc_reg : indeg_rd;
    assign unit_b = (state_reg == kts_pkg::ST_COUNT) ? CNT_W'(mx_bit) : '1;
    assign unit_y = unit_a + unit_b;

    // Hold the node count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kts_pkg::ST_IDLE:
            begin
                if (start_sort && (n_clip != '0))
                begin
                    state_next = kts_pkg::ST_COUNT;
                end
            end
            kts_pkg::ST_COUNT:
            begin
                if (j_last && i_last)
                begin
                    state_next = kts_pkg::ST_POP;
                end
            end
            kts_pkg::ST_POP:
            begin
                state_next = q_empty ? kts_pkg::ST_IDLE : kts_pkg::ST_SCAN;
            end
            kts_pkg::ST_SCAN:
            begin
                if (j_last)
                begin
                    state_next = kts_pkg::ST_POP;
                end
            end
            default:
            begin
                state_next = kts_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of each state
    always_comb
    begin
        q_ctrl      = '0;
        q_push_node = '0;
        indeg_we    = 1'b0;
        indeg_waddr = j_reg;
        emit        = 1'b0;
        emit_res    = '0;
        case (state_reg)
            kts_pkg::ST_IDLE:
            begin
                if (start_sort)
                begin
                    q_ctrl.clear = 1'b1;
                    if (n_clip == '0)
                    begin
                        emit               = 1'b1;
                        emit_res.last      = 1'b1;
                        emit_res.empty_res = 1'b1;
                    end
                end
            end
            kts_pkg::ST_COUNT:
            begin
                // Column done: store the in-degree, queue the node if free
                if (j_last)
                begin
                    indeg_we    = 1'b1;
                    indeg_waddr = i_reg;
                    if (unit_y == '0)
                    begin
                        q_ctrl.push = 1'b1;
                        q_push_node = i_reg;
                    end
                end
            end
            kts_pkg::ST_POP:
            begin
                if (!q_empty)
                begin
                    q_ctrl.pop        = 1'b1;
                    emit              = 1'b1;
                    emit_res.node     = kts_pkg::NODE_W'(q_head_node);
                    emit_res.position = kts_pkg::POS_W'(placed_reg);
                    emit_res.last     = (placed_inc == n_reg);
                end
                else if (placed_reg != n_reg)
                begin
                    // Nodes left over: flag the cycle
                    emit              = 1'b1;
                    emit_res.position = kts_pkg::POS_W'(placed_reg);
                    emit_res.last     = 1'b1;
                    emit_res.cyclic   = 1'b1;
                end
            end
            kts_pkg::ST_SCAN:
            begin
                // Successor found: drop its in-degree, queue it at zero
                if (mx_bit && (indeg_rd != '0))
                begin
                    indeg_we = 1'b1;
                    if (unit_y == '0)
                    begin
                        q_ctrl.push = 1'b1;
                        q_push_node = j_reg;
                    end
                end
            end
            default:
            begin
                q_ctrl = '0;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance counters and node pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            idx_reg    <= '0;
            acc_reg    <= '0;
            placed_reg <= '0;
        end
        else
        begin
            case (state_reg)
                kts_pkg::ST_IDLE:
                begin
                    if (start_sort)
                    begin
                        n_reg      <= n_clip;
                        i_reg      <= '0;
                        j_reg      <= '0;
                        acc_reg    <= '0;
                        placed_reg <= '0;
                    end
                end
                kts_pkg::ST_COUNT:
                begin
                    if (j_last)
                    begin
                        j_reg   <= '0;
                        acc_reg <= '0;
                        i_reg   <= i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        j_reg   <= j_reg + IDX_W'(1);
                        acc_reg <= unit_y;
                    end
                end
                kts_pkg::ST_POP:
                begin
                    if (!q_empty)
                    begin
                        idx_reg    <= q_head_node;
                        placed_reg <= placed_inc;
                        j_reg      <= '0;
                    end
                end
                kts_pkg::ST_SCAN:
                begin
                    j_reg <= j_last ? '0 : (j_reg + IDX_W'(1));
                end
                default:
                begin
                    j_reg <= '0;
                end
            endcase
        end
    end

    // In-degree store
    always_ff @(posedge clk)
    begin
        if (indeg_we)
        begin
            indeg_mem[indeg_waddr] <= unit_y;
        end
    end

    // Result register: one-cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            result_strobe_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= emit_res;
        end
    end

    assign result_strobe = result_strobe_reg;
    assign result        = result_reg;
    assign busy          = (state_reg != kts_pkg::ST_IDLE);

endmodule

`default_nettype wire

FILE: design/kahn_topological_sorter_core.sv
// Top level of the Kahn topological sorter.
//
// Add-edge, clear and unused commands are accepted whenever busy is low and leave it low.
// A sort with n nodes (node_count clipped to MAX_NODES) first counts
// in-degrees one matrix bit at a time, then for each placed node runs a pop
// step and a scan over its row, all through the single-bit matrix read port
// and the one shared count unit. busy is high for the whole run. Results
// appear one at a time on result with result_strobe high for exactly one
// cycle; the receiver cannot stall them and must take each transaction as it
// comes. Write node_count only while busy is low and no result is pending.
`default_nettype none

module kahn_topological_sorter_core #(
    parameter int MAX_NODES = kts_pkg::MAX_NODES_DEF
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  kts_pkg::cmd_t             cmd,
    output logic                      busy,
    input  wire                       cfg_we,
    input  wire [kts_pkg::CFG_W-1:0]  cfg_wdata,
    output logic                      result_strobe,
    output kts_pkg::result_t          result
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    logic                 accept;
    logic                 in_range;
    logic                 start_sort;
    kts_pkg::mx_ctrl_t    mx_ctrl;
    logic [IDX_W-1:0]     mx_row;
    logic [IDX_W-1:0]     mx_col;
    logic                 mx_bit;
    kts_pkg::q_ctrl_t     q_ctrl;
    logic [IDX_W-1:0]     q_push_node;
    logic [IDX_W-1:0]     q_head_node;
    logic                 q_empty;

    // Decode an accepted command transaction
    assign accept   = start && !busy;
    assign in_range = (int'(cmd.from_node) < MAX_NODES) && (int'(cmd.to_node) < MAX_NODES);

    always_comb
    begin
        mx_ctrl       = '0;
        mx_ctrl.add   = accept && (cmd.op == kts_pkg::OP_ADD_EDGE) && in_range;
        mx_ctrl.clear = accept && (cmd.op == kts_pkg::OP_CLEAR);
    end

    assign start_sort = accept && (cmd.op == kts_pkg::OP_SORT);

    kts_matrix #(
        .MAX_NODES (MAX_NODES),
        .IDX_W     (IDX_W)
    ) u_matrix (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mx_ctrl),
        .wr_row (IDX_W'(cmd.from_node)),
        .wr_col (IDX_W'(cmd.to_node)),
        .rd_row (mx_row),
        .rd_col (mx_col),
        .rd_bit (mx_bit)
    );

    kts_queue #(
        .MAX_NODES (MAX_NODES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .push_node (q_push_node),
        .head_node (q_head_node),
        .empty     (q_empty)
    );

    kts_seq #(
        .MAX_NODES (MAX_NODES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start_sort    (start_sort),
        .busy          (busy),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mx_row        (mx_row),
        .mx_col        (mx_col),
        .mx_bit        (mx_bit),
        .q_ctrl        (q_ctrl),
        .q_push_node   (q_push_node),
        .q_head_node   (q_head_node),
        .q_empty       (q_empty),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

`default_nettype wire

FILE: design/kts_checker.sv
// Port-level checks for the sorter core, bound to the top level.
`default_nettype none

module kts_checker (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  kts_pkg::cmd_t             cmd,
    input  wire                       busy,
    input  wire                       result_strobe,
    input  kts_pkg::result_t          result
);

    // A sort transaction either starts a run or answers at once as empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.op == kts_pkg::OP_SORT)) |=> (busy || result_strobe))
    else $error("sort accepted but neither busy nor a result followed");

    // Edge and clear transactions never occupy the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.op != kts_pkg::OP_SORT)) |=> !busy)
    else $error("non-sort transaction left the block busy");

    // An empty-sort result carries no other information
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.empty_res) |->
            (result.last && !result.cyclic && (result.node == '0)
             && (result.position == '0)))
    else $error("malformed empty-sort result");

    // A cycle flag always closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.cyclic) |-> (result.last && (result.node == '0)))
    else $error("cycle flag without last");

    // A result seen while idle is the final one of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !busy) |-> result.last)
    else $error("idle result that is not last");

endmodule

bind kahn_topological_sorter_core kts_checker u_kts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .cmd           (cmd),
    .busy          (busy),
    .result_strobe (result_strobe),
    .result        (result)
);

`default_nettype wire
